// ===== hw/rtl/pim_pkg.sv =====
package pim_pkg;

  localparam int unsigned ClkW   = 27;
  localparam int unsigned PreW   = 17;
  localparam int unsigned PerW   = 17;
  localparam int unsigned ValW   = 16;
  localparam int unsigned CntW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DutyW  = 16;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned StepW  = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ClkW-1:0] ClockReset = 27'd72000000;
  localparam logic [PreW-1:0] PreReset   = 17'd720;
  localparam logic [PerW-1:0] PerReset   = 17'd10000;

  localparam logic [CfgIdxW-1:0] CfgClock    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPrescale = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriod   = 2'd2;

  // Last step index of each division: the count runs down to zero.
  localparam logic [StepW-1:0] StepsFreq = StepW'(ClkW - 1);
  localparam logic [StepW-1:0] StepsDuty = StepW'(DutyW - 1);

  localparam logic [CntW-1:0]  CntMax  = '1;
  localparam logic [DutyW-1:0] DutyMax = '1;

  typedef enum logic [PhaseW-1:0] {
    PhFirst  = 2'd0,
    PhFall   = 2'd1,
    PhSecond = 2'd2
  } phase_e;

  typedef enum logic [11:0] {
    StIdle    = 12'b0000_0000_0001,
    StMul     = 12'b0000_0000_0010,
    StExt     = 12'b0000_0000_0100,
    StApply   = 12'b0000_0000_1000,
    StCheck   = 12'b0000_0001_0000,
    StDivPre  = 12'b0000_0010_0000,
    StLdFreq  = 12'b0000_0100_0000,
    StDivFreq = 12'b0000_1000_0000,
    StLdDuty  = 12'b0001_0000_0000,
    StDivDuty = 12'b0010_0000_0000,
    StDone    = 12'b0100_0000_0000,
    StEmit    = 12'b1000_0000_0000
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic ext;
    logic set_first;
    logic set_fall;
    logic set_span;
    logic check;
    logic ld_pre;
    logic ld_freq;
    logic ld_duty;
    logic step;
    logic commit_freq;
    logic commit_duty;
  } dp_cmd_t;

  typedef struct packed {
    logic cap;
    logic span_zero;
  } dp_status_t;

  typedef struct packed {
    logic              emit;
    logic              done;
    logic              zero;
    logic [PhaseW-1:0] phase;
  } ctl_result_t;

endpackage

// ===== hw/rtl/pim_in_if.sv =====
interface pim_in_if import pim_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            overflow_event;
  logic            capture_event;
  logic [ValW-1:0] capture_value;

  modport source(output valid, output overflow_event, output capture_event,
                 output capture_value, input ready);
  modport sink(input valid, input overflow_event, input capture_event,
               input capture_value, output ready);
endinterface

// ===== hw/rtl/pim_out_if.sv =====
interface pim_out_if import pim_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              measure_done;
  logic              zero_span;
  logic [ClkW-1:0]   frequency_hz;
  logic [DutyW-1:0]  duty_q16;
  logic [PhaseW-1:0] edge_phase;

  modport source(output valid, output measure_done, output zero_span,
                 output frequency_hz, output duty_q16, output edge_phase, input ready);
  modport sink(input valid, input measure_done, input zero_span,
               input frequency_hz, input duty_q16, input edge_phase, output ready);
endinterface

// ===== hw/rtl/pim_datapath.sv =====
module pim_datapath import pim_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ClkW-1:0]    cfg_data_i,
  input  logic               ovf_i,
  input  logic               cap_i,
  input  logic [ValW-1:0]    val_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  output logic [ClkW-1:0]    freq_o,
  output logic [DutyW-1:0]   duty_o
);

  logic [ClkW-1:0]  clock_q;
  logic [PreW-1:0]  pre_q;
  logic [PerW-1:0]  per_q;
  logic [ValW-1:0]  val_q;
  logic             cap_q;
  logic [CntW-1:0]  ovf_cnt_q;
  logic [TimeW-1:0] prod_q;
  logic [TimeW-1:0] ext_q;
  logic [ValW-1:0]  first_q;
  logic [TimeW-1:0] fall_q;
  logic [TimeW-1:0] span_q;
  logic [TimeW-1:0] high_q;
  logic             sat_q;
  logic [TimeW-1:0] rem_q, rem_d;
  logic [ClkW-1:0]  dvd_q;
  logic [TimeW-1:0] dvs_q;
  logic [ClkW-1:0]  quot_q;
  logic [ClkW-1:0]  freq_q;
  logic [DutyW-1:0] duty_q;

  logic [TimeW:0]   prod_full;
  logic [TimeW:0]   rem_sh;
  logic             qbit;
  logic [PreW-1:0]  pre_eff;

  assign prod_full = (TimeW+1)'(ovf_cnt_q) * (TimeW+1)'(per_q);
  assign pre_eff   = (pre_q == '0) ? PreW'(1) : pre_q;
  assign rem_sh    = {rem_q, dvd_q[ClkW-1]};
  assign qbit      = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    if (qbit) begin
      rem_d = TimeW'(rem_sh - {1'b0, dvs_q});
    end else begin
      rem_d = rem_sh[TimeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= ClockReset;
      pre_q   <= PreReset;
      per_q   <= PerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgClock:    clock_q <= cfg_data_i;
        CfgPrescale: pre_q   <= cfg_data_i[PreW-1:0];
        CfgPeriod:   per_q   <= cfg_data_i[PerW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_cnt_q <= '0;
      first_q   <= '0;
      fall_q    <= '0;
      freq_q    <= '0;
      duty_q    <= '0;
    end else begin
      if (cmd_i.load && ovf_i && ovf_cnt_q != CntMax) begin
        ovf_cnt_q <= ovf_cnt_q + CntW'(1);
      end else if (cmd_i.set_first) begin
        ovf_cnt_q <= '0;
      end
      if (cmd_i.set_first) begin
        first_q <= val_q;
      end
      if (cmd_i.set_fall) begin
        fall_q <= ext_q;
      end
      if (cmd_i.commit_freq) begin
        freq_q <= quot_q;
      end
      if (cmd_i.commit_duty) begin
        duty_q <= sat_q ? DutyMax : quot_q[DutyW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= val_i;
      cap_q <= cap_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[TimeW-1:0];
    end
    if (cmd_i.ext) begin
      ext_q <= TimeW'(val_q) + prod_q;
    end
    if (cmd_i.set_span) begin
      span_q <= ext_q - TimeW'(first_q);
      high_q <= fall_q - TimeW'(first_q);
    end
    if (cmd_i.check) begin
      sat_q <= (high_q >= span_q);
    end
    if (cmd_i.ld_pre) begin
      rem_q  <= '0;
      dvd_q  <= clock_q;
      dvs_q  <= TimeW'(pre_eff);
      quot_q <= '0;
    end else if (cmd_i.ld_freq) begin
      rem_q  <= '0;
      dvd_q  <= quot_q;
      dvs_q  <= span_q;
      quot_q <= '0;
    end else if (cmd_i.ld_duty) begin
      rem_q  <= high_q;
      dvd_q  <= '0;
      dvs_q  <= span_q;
      quot_q <= '0;
    end else if (cmd_i.step) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[ClkW-2:0], 1'b0};
      quot_q <= {quot_q[ClkW-2:0], qbit};
    end
  end

  assign status_o.cap       = cap_q;
  assign status_o.span_zero = (span_q == '0);
  assign freq_o             = freq_q;
  assign duty_o             = duty_q;

endmodule

// ===== hw/rtl/pim_controller.sv =====
module pim_controller import pim_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        out_free_i,
  input  dp_status_t  status_i,
  output dp_cmd_t     cmd_o,
  output ctl_result_t result_o
);

  ctl_state_e       state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic             zero_q, zero_d;
  logic             sat_seen;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    done_d   = done_q;
    zero_d   = zero_q;
    cmd_o    = '0;
    sat_seen = 1'b0;
    result_o = '{emit: 1'b0, done: done_q, zero: zero_q, phase: phase_q};

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          done_d     = 1'b0;
          zero_d     = 1'b0;
          state_d    = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StExt;
      end
      StExt: begin
        cmd_o.ext = 1'b1;
        state_d   = StApply;
      end
      StApply: begin
        state_d = StEmit;
        if (status_i.cap) begin
          unique case (phase_q)
            PhFirst: begin
              cmd_o.set_first = 1'b1;
              phase_d         = PhFall;
            end
            PhFall: begin
              cmd_o.set_fall = 1'b1;
              phase_d        = PhSecond;
            end
            PhSecond: begin
              cmd_o.set_span = 1'b1;
              phase_d        = PhFirst;
              state_d        = StCheck;
            end
            default: begin
              phase_d = PhFirst;
            end
          endcase
        end
      end
      StCheck: begin
        done_d = 1'b1;
        if (status_i.span_zero) begin
          zero_d  = 1'b1;
          state_d = StEmit;
        end else begin
          cmd_o.check  = 1'b1;
          cmd_o.ld_pre = 1'b1;
          cnt_d        = StepsFreq;
          state_d      = StDivPre;
        end
      end
      StDivPre: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - StepW'(1);
        if (cnt_q == '0) begin
          state_d = StLdFreq;
        end
      end
      StLdFreq: begin
        cmd_o.ld_freq = 1'b1;
        cnt_d         = StepsFreq;
        state_d       = StDivFreq;
      end
      StDivFreq: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - StepW'(1);
        if (cnt_q == '0) begin
          state_d = StLdDuty;
        end
      end
      StLdDuty: begin
        cmd_o.commit_freq = 1'b1;
        cmd_o.ld_duty     = 1'b1;
        cnt_d             = StepsDuty;
        state_d           = StDivDuty;
      end
      StDivDuty: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - StepW'(1);
        if (cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        sat_seen          = 1'b1;
        cmd_o.commit_duty = sat_seen;
        state_d           = StEmit;
      end
      StEmit: begin
        if (out_free_i) begin
          result_o.emit = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= PhFirst;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      zero_q  <= zero_d;
    end
  end

endmodule

// ===== hw/rtl/pwm_input_capture_meter.sv =====
// Channel   Dir  Payload
// in_if     in   overflow_event, capture_event, capture_value[15:0]
// out_if    out  measure_done, zero_span, frequency_hz[26:0], duty_q16[15:0], edge_phase[1:0]
// cfg       in   cfg_we_i, cfg_idx_i[1:0] (0 clock, 1 prescale, 2 period), cfg_data_i[26:0]
//
// One request is worked on at a time; ready is high only while the controller is idle.
// A request without a completed period passes the multiply, extend and apply states
// before its result is emitted; a completed period with zero span passes the check state too.
// Any other completed period is then worked through one shared restoring divider
// that runs 27, 27 and 16 steps for the prescaled clock, the frequency and the duty.
// Reset clears the measurement state and loads the register defaults; a stalled
// result sits in the output register while the next request is accepted.
module pwm_input_capture_meter import pim_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  pim_in_if.sink             in_if,
  pim_out_if.source          out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ClkW-1:0]    cfg_data_i
);

  dp_cmd_t          cmd;
  dp_status_t       status;
  ctl_result_t      result;
  logic [ClkW-1:0]  freq;
  logic [DutyW-1:0] duty;
  logic             out_valid_q;
  logic             out_free;

  assign out_free = !out_valid_q || out_if.ready;

  pim_controller u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd),
    .result_o   (result)
  );

  pim_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ovf_i      (in_if.overflow_event),
    .cap_i      (in_if.capture_event),
    .val_i      (in_if.capture_value),
    .cmd_i      (cmd),
    .status_o   (status),
    .freq_o     (freq),
    .duty_o     (duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.emit) begin
      out_if.measure_done <= result.done;
      out_if.zero_span    <= result.zero;
      out_if.frequency_hz <= freq;
      out_if.duty_q16     <= duty;
      out_if.edge_phase   <= result.phase;
    end
  end

  assign out_if.valid = out_valid_q;

  a_done_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.measure_done |-> out_if.edge_phase == PhFirst)
    else $error("completed measurement did not return to the first edge");

  a_zero_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.zero_span |-> out_if.measure_done)
    else $error("zero span flagged without a completed measurement");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("second request accepted while one is in progress");

endmodule
